// File: src/mlfq_pkg.sv
`default_nettype none
package mlfq_pkg;
  localparam int NumSlots = 64;
  localparam int SlotW = $clog2(NumSlots);
  localparam int CntW = $clog2(NumSlots + 1);

  typedef enum logic [3:0] {
    CmdTick = 4'd0, CmdDispatch = 4'd1, CmdAdmit = 4'd2, CmdYield = 4'd3,
    CmdSleep = 4'd4, CmdExit = 4'd5, CmdWake = 4'd6, CmdFree = 4'd7,
    CmdQuery = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    StUnused = 3'd0, StRunnable = 3'd1, StRunning = 3'd2, StSleeping = 3'd3,
    StZombie = 3'd4
  } slot_state_e;

  typedef enum logic [1:0] {
    StatOk = 2'd0, StatNone = 2'd1, StatWrong = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CfgBoostPeriod = 2'd0, CfgSliceTop = 2'd1, CfgSliceMiddle = 2'd2,
    CfgSliceBottom = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    FsmIdle, FsmBoostRd, FsmBoostWr, FsmScanRd, FsmScanChk, FsmRd, FsmAct,
    FsmWb, FsmOut
  } fsm_e;

  typedef struct packed {
    logic [2:0] st;
    logic [1:0] lvl;
    logic [7:0] spent;
    logic [31:0] ticks;
    logic [31:0] disp;
  } entry_t;
endpackage
`default_nettype wire

// File: src/mlfq_process_scheduler.sv
// Each command passes read, act, write-back and output states before result valid; an unknown
// command goes straight to output. A tick that boosts first passes over every slot. Admit and
// dispatch walk the slots, reading each in turn; dispatch walks up to three levels.
// One word in flight at a time; next word accepted once the result is taken.
// Reset is asynchronous; a clearing pass over every slot follows reset.
`default_nettype none
module mlfq_process_scheduler
  import mlfq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  command_i,
  input  wire logic [5:0]  slot_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [5:0]       task_slot_o,
  output logic [1:0]       level_o,
  output logic [7:0]       slice_spent_o,
  output logic [31:0]      run_ticks_o,
  output logic [31:0]      dispatch_count_o,
  output logic             preempted_o,
  output logic             boosted_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  entry_t mem_q [NumSlots];
  entry_t rd_q;
  logic mem_we;
  logic [SlotW-1:0] mem_wa, mem_ra;
  entry_t mem_wd;

  fsm_e state_q, state_d;
  logic clr_q;
  logic [CntW-1:0] clr_cnt_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [1:0] lvl_q, lvl_d;
  logic [3:0] cmd_q;
  logic [5:0] slot_q;
  logic [15:0] boost_period_q, boost_cnt_q, boost_cnt_d;
  logic [7:0] slice_top_q, slice_mid_q, slice_bot_q;
  logic [SlotW-1:0] cur_q, cur_d, tgt_q, tgt_d;
  logic cur_v_q, cur_v_d, boosted_q, boosted_d, found_q, found_d;
  entry_t new_q, new_d;
  logic wb_q, wb_d;
  logic [1:0] stat_q, stat_d;
  logic pre_q, pre_d, zero_q, zero_d;
  logic [5:0] rslot_q, rslot_d;
  logic out_v_q;
  logic [7:0] slice_sel, spent_inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  assign in_stall_o  = (state_q != FsmIdle) || clr_q || out_v_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    case (rd_q.lvl)
      2'd0:    slice_sel = slice_top_q;
      2'd1:    slice_sel = slice_mid_q;
      default: slice_sel = slice_bot_q;
    endcase
    spent_inc = rd_q.spent + 8'd1;
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    lvl_d = lvl_q;
    boost_cnt_d = boost_cnt_q;
    cur_d = cur_q;
    cur_v_d = cur_v_q;
    tgt_d = tgt_q;
    boosted_d = boosted_q;
    found_d = found_q;
    new_d = new_q;
    wb_d = wb_q;
    stat_d = stat_q;
    pre_d = pre_q;
    zero_d = zero_q;
    rslot_d = rslot_q;
    case (state_q)
      FsmIdle: begin
        if (in_valid_i && !in_stall_o) begin
          boosted_d = 1'b0;
          found_d = 1'b0;
          idx_d = '0;
          lvl_d = '0;
          wb_d = 1'b0;
          pre_d = 1'b0;
          zero_d = 1'b0;
          stat_d = StatOk;
          tgt_d = cur_q;
          case (command_i)
            CmdTick: begin
              boost_cnt_d = boost_cnt_q + 16'd1;
              if (boost_cnt_d >= boost_period_q) begin
                boost_cnt_d = '0;
                boosted_d = 1'b1;
                state_d = FsmBoostRd;
              end else begin
                state_d = FsmRd;
              end
            end
            CmdDispatch, CmdAdmit: state_d = FsmRd;
            CmdYield, CmdSleep, CmdExit: state_d = FsmRd;
            CmdWake, CmdFree, CmdQuery: begin
              tgt_d = slot_i[SlotW-1:0];
              state_d = FsmRd;
            end
            default: begin
              stat_d = StatNone;
              zero_d = 1'b1;
              state_d = FsmOut;
            end
          endcase
        end
      end
      FsmBoostRd: state_d = FsmBoostWr;
      FsmBoostWr: begin
        if (idx_q == CntW'(NumSlots - 1)) begin
          state_d = FsmRd;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      FsmScanRd: state_d = FsmScanChk;
      FsmScanChk: begin
        if ((cmd_q == CmdAdmit && rd_q.st == StUnused) ||
            (cmd_q == CmdDispatch && rd_q.st == StRunnable && rd_q.lvl == lvl_q)) begin
          found_d = 1'b1;
          tgt_d = idx_q[SlotW-1:0];
          state_d = FsmRd;
        end else if (idx_q == CntW'(NumSlots - 1)) begin
          idx_d = '0;
          if (cmd_q == CmdDispatch && lvl_q != 2'd2) begin
            lvl_d = lvl_q + 2'd1;
            state_d = FsmScanRd;
          end else begin
            stat_d = StatNone;
            zero_d = 1'b1;
            state_d = FsmOut;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = FsmScanRd;
        end
      end
      FsmRd: state_d = FsmAct;
      FsmAct: begin
        new_d = rd_q;
        rslot_d = 6'(tgt_q);
        state_d = FsmWb;
        case (cmd_q)
          CmdTick: begin
            if (!(cur_v_q && rd_q.st == StRunning)) begin
              stat_d = StatNone;
              zero_d = 1'b1;
            end else begin
              wb_d = 1'b1;
              new_d.ticks = rd_q.ticks + 32'd1;
              new_d.spent = spent_inc;
              if (spent_inc >= slice_sel) begin
                if (rd_q.lvl < 2'd2) new_d.lvl = rd_q.lvl + 2'd1;
                new_d.spent = '0;
                new_d.st = StRunnable;
                cur_v_d = 1'b0;
                pre_d = 1'b1;
              end
            end
          end
          CmdDispatch: begin
            if (cur_v_q && rd_q.st == StRunning) begin
              stat_d = StatWrong;
            end else if (!found_q) begin
              idx_d = '0;
              lvl_d = '0;
              state_d = FsmScanRd;
            end else begin
              wb_d = 1'b1;
              new_d.st = StRunning;
              new_d.disp = rd_q.disp + 32'd1;
              cur_d = tgt_q;
              cur_v_d = 1'b1;
            end
          end
          CmdAdmit: begin
            if (!found_q) begin
              state_d = FsmScanRd;
            end else begin
              wb_d = 1'b1;
              new_d = '{st: StRunnable, lvl: 2'd0, spent: 8'd0, ticks: 32'd0, disp: 32'd0};
            end
          end
          CmdYield, CmdSleep, CmdExit: begin
            if (!(cur_v_q && rd_q.st == StRunning)) begin
              stat_d = StatNone;
              zero_d = 1'b1;
            end else begin
              wb_d = 1'b1;
              new_d.st = (cmd_q == CmdYield) ? StRunnable :
                         (cmd_q == CmdSleep) ? StSleeping : StZombie;
              cur_v_d = 1'b0;
            end
          end
          CmdQuery: begin
            if (rd_q.st == StUnused) stat_d = StatWrong;
          end
          default: begin
            if (rd_q.st != ((cmd_q == CmdWake) ? StSleeping : StZombie)) begin
              stat_d = StatWrong;
            end else begin
              wb_d = 1'b1;
              new_d.st = (cmd_q == CmdWake) ? StRunnable : StUnused;
            end
          end
        endcase
      end
      FsmWb: state_d = FsmOut;
      FsmOut: state_d = FsmIdle;
      default: state_d = FsmIdle;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q[SlotW-1:0];
    mem_wd = rd_q;
    mem_ra = idx_q[SlotW-1:0];
    if (clr_q) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q[SlotW-1:0];
      mem_wd = '0;
    end else begin
      case (state_q)
        FsmBoostRd: mem_ra = idx_q[SlotW-1:0];
        FsmBoostWr: begin
          mem_ra = idx_q[SlotW-1:0] + 1'b1;
          if (rd_q.st inside {StRunnable, StRunning}) begin
            mem_we = 1'b1;
            mem_wd.lvl = '0;
            mem_wd.spent = '0;
          end
        end
        FsmRd: mem_ra = tgt_q;
        FsmWb: begin
          mem_we = wb_q;
          mem_wa = tgt_q;
          mem_wd = new_q;
        end
        default: mem_ra = idx_q[SlotW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsmIdle;
      clr_q <= 1'b1;
      clr_cnt_q <= '0;
      idx_q <= '0;
      lvl_q <= '0;
      boost_cnt_q <= '0;
      cur_q <= '0;
      cur_v_q <= 1'b0;
      boosted_q <= 1'b0;
      found_q <= 1'b0;
      wb_q <= 1'b0;
      out_v_q <= 1'b0;
      boost_period_q <= 16'd10;
      slice_top_q <= 8'd4;
      slice_mid_q <= 8'd8;
      slice_bot_q <= 8'd16;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == CntW'(NumSlots - 1)) clr_q <= 1'b0;
      end
      state_q <= state_d;
      idx_q <= idx_d;
      lvl_q <= lvl_d;
      boost_cnt_q <= boost_cnt_d;
      cur_q <= cur_d;
      cur_v_q <= cur_v_d;
      boosted_q <= boosted_d;
      found_q <= found_d;
      wb_q <= wb_d;
      if (state_q == FsmOut) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgBoostPeriod: boost_period_q <= cfg_data_i;
          CfgSliceTop:    slice_top_q <= cfg_data_i[7:0];
          CfgSliceMiddle: slice_mid_q <= cfg_data_i[7:0];
          CfgSliceBottom: slice_bot_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FsmIdle && in_valid_i && !in_stall_o) begin
      cmd_q <= command_i;
      slot_q <= slot_i;
    end
    tgt_q <= tgt_d;
    new_q <= new_d;
    stat_q <= stat_d;
    pre_q <= pre_d;
    zero_q <= zero_d;
    rslot_q <= rslot_d;
    if (state_q == FsmOut) begin
      status_o <= stat_q;
      preempted_o <= pre_q;
      boosted_o <= boosted_q && cmd_q == CmdTick;
      if (zero_q) begin
        task_slot_o <= '0;
        level_o <= '0;
        slice_spent_o <= '0;
        run_ticks_o <= '0;
        dispatch_count_o <= '0;
      end else begin
        task_slot_o <= (cmd_q inside {CmdWake, CmdFree, CmdQuery}) ? slot_q : rslot_q;
        level_o <= new_q.lvl;
        slice_spent_o <= new_q.spent;
        run_ticks_o <= new_q.ticks;
        dispatch_count_o <= new_q.disp;
      end
    end
  end

  assign out_valid_o = out_v_q;

`ifndef SYNTH
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> in_stall_o) else $error("accept during clear");
  a_out_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FsmOut |=> out_valid_o && state_q == FsmIdle) else $error("out");
  a_wb_only_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !clr_q) |-> (state_q == FsmWb || state_q == FsmBoostWr))
    else $error("stray write");
`endif
endmodule
`default_nettype wire
